// File: src/cholesky_decomposition_top_defines.svh
// Assertion macros used by the factorization datapath.
// Depends on nothing; included by the datapath module, which carries the assertions.
`ifndef CHOLESKY_DECOMPOSITION_TOP_DEFINES_SVH
`define CHOLESKY_DECOMPOSITION_TOP_DEFINES_SVH

// Asserts that a condition implies a consequence in the same cycle.
`define CHOL_ASSERT_IMPL(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);

// Asserts that a condition implies a consequence in the next cycle.
`define CHOL_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);

`endif

// File: src/chol_pkg.sv
// Package with the shared types, constants and command structs of the factorization.
// Depends on nothing.
package chol_pkg;
   localparam int MAX_ORDER_DEFAULT = 8;
   localparam logic [3:0] ORDER_RESET = 4'd3;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_SUM_RD,
      ST_SUM_MUL,
      ST_SUM_ACC,
      ST_DIFF,
      ST_SQRT,
      ST_DIV,
      ST_WRITE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic start_entry;
      logic rd_prod;
      logic mul;
      logic acc;
      logic diff;
      logic start_sqrt;
      logic start_div;
      logic write_entry;
      logic clear_error;
   } dp_cmd_type;

   typedef struct packed {
      logic unit_busy;
      logic is_diag;
   } dp_status_type;
endpackage

// File: src/chol_datapath.sv
// Datapath: element and factor memories, product accumulator, square root and divider units.
// Depends on chol_pkg and the assertion macros header.
`include "cholesky_decomposition_top_defines.svh"
module chol_datapath #(
   parameter int MAX_ORDER = 8,
   parameter int IW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1
) (
   input  logic clock,
   input  logic reset,
   input  logic wr_en,
   input  logic [IW-1:0] wr_row,
   input  logic [IW-1:0] wr_col,
   input  logic signed [31:0] wr_value,
   input  logic [IW-1:0] idx_i,
   input  logic [IW-1:0] idx_j,
   input  logic [IW-1:0] idx_k,
   input  chol_pkg::dp_cmd_type cmd,
   output chol_pkg::dp_status_type status,
   output logic signed [31:0] entry_value,
   output logic error_flag
);
   import chol_pkg::*;

   localparam int DEPTH = MAX_ORDER * MAX_ORDER;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic signed [31:0] mat_mem [DEPTH];
   logic signed [31:0] fac_mem [DEPTH];

   function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] r, input logic [IW-1:0] c);
      logic [2*IW+1:0] a;
      a = {2'b0, IW'(0), r} * (2*IW+2)'(MAX_ORDER) + {2'b0, IW'(0), c};
      return a[AW-1:0];
   endfunction

   logic signed [31:0] mat_rd_ff, fac_a_ff, fac_b_ff;
   logic [AW-1:0] fa_addr, fb_addr;
   logic [AW-1:0] fw_addr;

   always_comb begin
      fa_addr = addr_of(idx_i, idx_k);
      fb_addr = addr_of(idx_j, idx_k);
      fw_addr = addr_of(idx_i, idx_j);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mat_mem[addr_of(wr_row, wr_col)] <= wr_value;
      end
      mat_rd_ff <= mat_mem[fw_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.write_entry) begin
         fac_mem[fw_addr] <= entry_value;
      end
      fac_a_ff <= fac_mem[fa_addr];
      fac_b_ff <= fac_mem[fb_addr];
   end

   logic signed [31:0] den_ff, den_in;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [63:0] sum_ff, sum_in;
   logic signed [63:0] d_ff, d_in;
   logic signed [63:0] rounded;

   assign rounded = (prod_ff + 64'sd32768) >>> 16;

   always_comb begin
      den_in = den_ff;
      prod_in = prod_ff;
      sum_in = sum_ff;
      d_in = d_ff;
      if (cmd.start_entry) begin
         sum_in = '0;
      end
      if (cmd.rd_prod && idx_k == '0 && !cmd.mul) begin
         den_in = den_ff;
      end
      if (cmd.mul) begin
         prod_in = 64'(fac_a_ff) * 64'(fac_b_ff);
      end
      if (cmd.acc) begin
         sum_in = sum_ff + rounded;
      end
      if (cmd.diff) begin
         d_in = 64'(mat_rd_ff) - sum_ff;
         den_in = fac_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      den_ff <= den_in;
      prod_ff <= prod_in;
      sum_ff <= sum_in;
      d_ff <= d_in;
   end

   // Square root: radicand d << 16 (under 2^62 when in range), two bits per cycle.
   logic [63:0] sq_v_ff, sq_v_in, sq_res_ff, sq_res_in, sq_bit_ff, sq_bit_in;
   logic sq_busy_ff, sq_busy_in;
   logic sq_ovf_ff, sq_ovf_in, sq_neg_ff, sq_neg_in;

   // Divider: (|d| << 16) / den, bit-serial, one quotient bit per cycle.
   logic [63:0] dv_num_ff, dv_num_in, dv_q_ff, dv_q_in;
   logic [32:0] dv_rem_ff, dv_rem_in;
   logic [6:0] dv_cnt_ff, dv_cnt_in;
   logic dv_busy_ff, dv_busy_in;
   logic dv_neg_ff, dv_neg_in, dv_sat_ff, dv_sat_in, dv_zero_ff, dv_zero_in;
   logic [33:0] dv_trial;
   logic [32:0] dv_shift;
   logic [63:0] mag;
   logic err_ff, err_in;

   assign mag = d_ff[63] ? 64'(-d_ff) : 64'(d_ff);

   always_comb begin
      sq_v_in = sq_v_ff;
      sq_res_in = sq_res_ff;
      sq_bit_in = sq_bit_ff;
      sq_busy_in = sq_busy_ff;
      sq_ovf_in = sq_ovf_ff;
      sq_neg_in = sq_neg_ff;
      if (cmd.start_sqrt) begin
         sq_v_in = {d_ff[47:0], 16'b0};
         sq_res_in = '0;
         sq_bit_in = 64'd1 << 62;
         sq_busy_in = 1'b1;
         sq_neg_in = (d_ff <= 64'sd0);
         sq_ovf_in = (d_ff >= (64'sd1 <<< 46));
      end else if (sq_busy_ff) begin
         if (sq_bit_ff == '0) begin
            sq_busy_in = 1'b0;
         end else begin
            if (sq_v_ff >= sq_res_ff + sq_bit_ff) begin
               sq_v_in = sq_v_ff - (sq_res_ff + sq_bit_ff);
               sq_res_in = (sq_res_ff >> 1) + sq_bit_ff;
            end else begin
               sq_res_in = sq_res_ff >> 1;
            end
            sq_bit_in = sq_bit_ff >> 2;
         end
      end
   end

   always_comb begin
      dv_num_in = dv_num_ff;
      dv_q_in = dv_q_ff;
      dv_rem_in = dv_rem_ff;
      dv_cnt_in = dv_cnt_ff;
      dv_busy_in = dv_busy_ff;
      dv_neg_in = dv_neg_ff;
      dv_sat_in = dv_sat_ff;
      dv_zero_in = dv_zero_ff;
      dv_shift = {dv_rem_ff[31:0], dv_num_ff[63]};
      dv_trial = {1'b0, dv_shift} - {2'b0, den_ff};
      if (cmd.start_div) begin
         dv_num_in = {mag[47:0], 16'b0};
         dv_q_in = '0;
         dv_rem_in = '0;
         dv_cnt_in = 7'd64;
         dv_busy_in = 1'b1;
         dv_neg_in = d_ff[63];
         dv_sat_in = (mag >= (64'd1 << 47));
         dv_zero_in = (den_ff <= 32'sd0);
      end else if (dv_busy_ff) begin
         if (dv_cnt_ff == '0) begin
            dv_busy_in = 1'b0;
         end else begin
            dv_num_in = dv_num_ff << 1;
            if (!dv_trial[33]) begin
               dv_rem_in = dv_trial[32:0];
               dv_q_in = {dv_q_ff[62:0], 1'b1};
            end else begin
               dv_rem_in = dv_shift;
               dv_q_in = {dv_q_ff[62:0], 1'b0};
            end
            dv_cnt_in = dv_cnt_ff - 7'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_busy_ff <= 1'b0;
         dv_busy_ff <= 1'b0;
         err_ff <= 1'b0;
      end else begin
         sq_busy_ff <= sq_busy_in;
         dv_busy_ff <= dv_busy_in;
         err_ff <= err_in;
      end
      sq_v_ff <= sq_v_in;
      sq_res_ff <= sq_res_in;
      sq_bit_ff <= sq_bit_in;
      sq_ovf_ff <= sq_ovf_in;
      sq_neg_ff <= sq_neg_in;
      dv_num_ff <= dv_num_in;
      dv_q_ff <= dv_q_in;
      dv_rem_ff <= dv_rem_in;
      dv_cnt_ff <= dv_cnt_in;
      dv_neg_ff <= dv_neg_in;
      dv_sat_ff <= dv_sat_in;
      dv_zero_ff <= dv_zero_in;
   end

   always_comb begin
      err_in = err_ff;
      if (cmd.clear_error) begin
         err_in = 1'b0;
      end
      if (cmd.write_entry && status.is_diag && sq_neg_ff) begin
         err_in = 1'b1;
      end
   end

   always_comb begin
      if (status.is_diag) begin
         if (sq_neg_ff) begin
            entry_value = '0;
         end else if (sq_ovf_ff || sq_res_ff > 64'h7FFF_FFFF) begin
            entry_value = 32'sh7FFF_FFFF;
         end else begin
            entry_value = sq_res_ff[31:0];
         end
      end else if (dv_zero_ff) begin
         entry_value = '0;
      end else if (dv_neg_ff) begin
         if (dv_sat_ff || dv_q_ff >= (64'd1 << 31)) begin
            entry_value = 32'sh8000_0000;
         end else begin
            entry_value = 32'(-dv_q_ff[31:0]);
         end
      end else if (dv_sat_ff || dv_q_ff > 64'h7FFF_FFFF) begin
         entry_value = 32'sh7FFF_FFFF;
      end else begin
         entry_value = dv_q_ff[31:0];
      end
   end

   assign error_flag = err_in;
   assign status.is_diag = (idx_i == idx_j);
   assign status.unit_busy = sq_busy_ff || dv_busy_ff || cmd.start_sqrt || cmd.start_div;

   `CHOL_ASSERT_IMPL(a_units_exclusive, clock, reset, sq_busy_ff, !dv_busy_ff,
      "square root and divider busy together")
   `CHOL_ASSERT_NEXT(a_div_starts, clock, reset, cmd.start_div, dv_busy_ff,
      "divider did not start")
   `CHOL_ASSERT_IMPL(a_no_write_busy, clock, reset, cmd.write_entry,
      !sq_busy_ff && !dv_busy_ff, "entry written while a unit is busy")
endmodule

// File: src/chol_ctrl.sv
// Controller state machine: sequences loading, the per-entry computation and emission.
// Depends on chol_pkg.
module chol_ctrl #(
   parameter int MAX_ORDER = 8,
   parameter int IW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1
) (
   input  logic clock,
   input  logic reset,
   input  logic [3:0] order,
   input  logic req_valid,
   input  logic load_last,
   output logic req_stall,
   input  logic rsp_stall,
   output logic rsp_valid,
   output logic [IW-1:0] idx_i,
   output logic [IW-1:0] idx_j,
   output logic [IW-1:0] idx_k,
   output logic last_entry,
   output chol_pkg::dp_cmd_type cmd,
   input  chol_pkg::dp_status_type status
);
   import chol_pkg::*;

   state_type state_ff, state_in;
   logic [IW-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [IW-1:0] n_max;
   logic [4:0] order_c;

   always_comb begin
      order_c = {1'b0, order};
      if (order_c == '0) begin
         order_c = 5'd1;
      end
      if (order_c > 5'(MAX_ORDER)) begin
         order_c = 5'(MAX_ORDER);
      end
      n_max = IW'(order_c - 5'd1);
   end

   assign idx_i = i_ff;
   assign idx_j = j_ff;
   assign idx_k = k_ff;
   assign last_entry = (i_ff == n_max) && (j_ff == i_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         i_ff <= '0;
         j_ff <= '0;
         k_ff <= '0;
      end else begin
         state_ff <= state_in;
         i_ff <= i_in;
         j_ff <= j_in;
         k_ff <= k_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      i_in = i_ff;
      j_in = j_ff;
      k_in = k_ff;
      cmd = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            req_stall = 1'b0;
            if (req_valid && load_last) begin
               i_in = '0;
               j_in = '0;
               k_in = '0;
               cmd.clear_error = 1'b1;
               state_in = ST_SUM_RD;
            end
         end
         ST_SUM_RD: begin
            if (k_ff == '0) begin
               cmd.start_entry = 1'b1;
            end
            if (k_ff == j_ff) begin
               state_in = ST_DIFF;
            end else begin
               cmd.rd_prod = 1'b1;
               state_in = ST_SUM_MUL;
            end
         end
         ST_SUM_MUL: begin
            cmd.mul = 1'b1;
            state_in = ST_SUM_ACC;
         end
         ST_SUM_ACC: begin
            cmd.acc = 1'b1;
            k_in = k_ff + IW'(1);
            state_in = ST_SUM_RD;
         end
         ST_DIFF: begin
            cmd.diff = 1'b1;
            state_in = status.is_diag ? ST_SQRT : ST_DIV;
         end
         ST_SQRT: begin
            cmd.start_sqrt = 1'b1;
            state_in = ST_WRITE;
         end
         ST_DIV: begin
            cmd.start_div = 1'b1;
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (!status.unit_busy) begin
               cmd.write_entry = 1'b1;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               k_in = '0;
               if (last_entry) begin
                  state_in = ST_LOAD;
               end else if (j_ff == i_ff) begin
                  i_in = i_ff + IW'(1);
                  j_in = '0;
                  state_in = ST_SUM_RD;
               end else begin
                  j_in = j_ff + IW'(1);
                  state_in = ST_SUM_RD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end
endmodule

// File: src/cholesky_decomposition_top.sv
// Top level of the Cholesky factorization: register, result holding stage and wiring.
// Depends on chol_pkg, chol_ctrl and chol_datapath.
//
// Channel   Direction   Handshake            Payload
// req       in          req_valid/req_stall  elem_row, elem_col, elem_value, load_last
// rsp       out         rsp_valid/rsp_stall  out_row, out_col, factor_value, pivot_error,
//                                            result_last
// csr       in          csr_write_enable     csr_matrix_order
//
// Load transactions are accepted back to back while the controller is loading. Each factor
// entry (i,j) goes through product accumulation through one 32x32 multiplier and the
// difference, the start of a unit, the square root unit or the bit-serial divider, a write once
// the unit is idle, and an emit state that holds the entry while the result is stalled.
// Input is stalled from the last element until the final entry has been taken.
// Reset clears the control state and the error flag; the matrix memory is not cleared.
module cholesky_decomposition_top #(
   parameter int MAX_ORDER = chol_pkg::MAX_ORDER_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_write_enable,
   input  logic [3:0] csr_matrix_order,
   input  logic req_valid,
   output logic req_stall,
   input  logic [2:0] req_elem_row,
   input  logic [2:0] req_elem_col,
   input  logic signed [31:0] req_elem_value,
   input  logic req_load_last,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [2:0] rsp_out_row,
   output logic [2:0] rsp_out_col,
   output logic signed [31:0] rsp_factor_value,
   output logic rsp_pivot_error,
   output logic rsp_result_last
);
   import chol_pkg::*;

   localparam int IW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

   logic [3:0] order_ff;
   logic [IW-1:0] idx_i, idx_j, idx_k;
   logic last_entry, error_flag, wr_en;
   logic signed [31:0] entry_value;
   dp_cmd_type cmd;
   dp_status_type status;
   logic [IW-1:0] wr_row, wr_col;
   logic signed [31:0] val_ff;
   logic err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= ORDER_RESET;
      end else if (csr_write_enable) begin
         order_ff <= csr_matrix_order;
      end
   end

   assign wr_row = IW'(req_elem_row);
   assign wr_col = IW'(req_elem_col);
   assign wr_en = req_valid && !req_stall && (req_elem_col <= req_elem_row) &&
      ({2'b0, req_elem_row} < 5'(MAX_ORDER)) && ({2'b0, req_elem_col} < 5'(MAX_ORDER));

   chol_ctrl #(.MAX_ORDER(MAX_ORDER), .IW(IW)) u_ctrl (
      .clock(clock), .reset(reset), .order(order_ff),
      .req_valid(req_valid), .load_last(req_load_last), .req_stall(req_stall),
      .rsp_stall(rsp_stall), .rsp_valid(rsp_valid),
      .idx_i(idx_i), .idx_j(idx_j), .idx_k(idx_k), .last_entry(last_entry),
      .cmd(cmd), .status(status)
   );

   chol_datapath #(.MAX_ORDER(MAX_ORDER), .IW(IW)) u_dp (
      .clock(clock), .reset(reset), .wr_en(wr_en), .wr_row(wr_row), .wr_col(wr_col),
      .wr_value(req_elem_value), .idx_i(idx_i), .idx_j(idx_j), .idx_k(idx_k),
      .cmd(cmd), .status(status), .entry_value(entry_value), .error_flag(error_flag)
   );

   always_ff @(posedge clock) begin
      if (cmd.write_entry) begin
         val_ff <= entry_value;
      end
      if (reset) begin
         err_ff <= 1'b0;
      end else if (cmd.write_entry) begin
         err_ff <= error_flag;
      end
   end

   assign rsp_out_row = 3'(idx_i);
   assign rsp_out_col = 3'(idx_j);
   assign rsp_factor_value = val_ff;
   assign rsp_pivot_error = err_ff;
   assign rsp_result_last = last_entry;
endmodule
